/* src/hsla_pkg.sv */
// ----------------------------------------------------------------------------
// hsla_pkg: shared types, constants and helpers for the HSL adjust pipeline.
// Holds the register indexes, the divider stage count, the pipeline
// sideband type and the constant-divisor helpers.
// ----------------------------------------------------------------------------
package hsla_pkg;

  localparam int HUE_FULL  = 1536;
  localparam int HUE_SEXT  = 256;
  localparam int DIV_STEPS = 9;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_HUE  = 3'd1;
  localparam logic [2:0] REG_SAT  = 3'd2;
  localparam logic [2:0] REG_LIT  = 3'd3;
  localparam logic [2:0] REG_VIB  = 3'd4;

  typedef enum logic [1:0] {
    CH_RAMP = 2'd0,
    CH_HI   = 2'd1,
    CH_LO   = 2'd2
  } hsla_chan_cls_t;

  // Data that rides alongside the two divisions.
  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  cov;
    logic [7:0]  lv;
    logic        grey;
    logic        hneg;
    logic [10:0] hbase;
  } hsla_side_t;

  // x / 255 for x up to 130050, by reciprocal multiply.
  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [34:0] p;
    p = 35'(x) * 35'd131587;
    return p[33:25];
  endfunction

  // x / 100 for x up to 32767, by reciprocal multiply.
  function automatic logic [8:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd5243;
    return p[27:19];
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    logic [7:0] res;
    res = v[7:0];
    if (v < 12'sd0) begin
      res = 8'd0;
    end else if (v > 12'sd255) begin
      res = 8'd255;
    end
    return res;
  endfunction

endpackage

/* src/hsl_hue_saturation_adjust.sv */
// ----------------------------------------------------------------------------
// hsl_hue_saturation_adjust: per-pixel hue, saturation, lightness and
// vibrance adjustment of an ARGB stream, blended by selection coverage.
// ----------------------------------------------------------------------------
// Usage: each input request carries one packed ARGB pixel and an 8-bit
// coverage value; each output request carries the adjusted pixel with alpha
// unchanged. Both channels use valid and stall, and a request moves at a
// clock edge with valid high and stall low.
// The block is a fixed pipeline of 19 register stages, and one pixel is taken
// every cycle unless the pipeline holds. The nine stages in the middle are the
// pipelined dividers that produce saturation and hue; the rest hold the input
// capture, the adjust math, the HSL to RGB conversion and the coverage blend.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and in_stall is raised, so nothing is dropped or repeated.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while the
// pipeline is empty. A synchronous reset clears all valid bits and sets
// every configuration register to zero.
// ----------------------------------------------------------------------------
module hsl_hue_saturation_adjust (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pixel_in,
  input  logic [7:0]  in_coverage,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_out,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);
  import hsla_pkg::*;

  logic adv;

  // Configuration registers.
  logic              mode_r;
  logic signed [8:0] hue_deg_r;
  logic signed [7:0] sat_pct_r, lit_pct_r, vib_pct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      hue_deg_r <= '0;
      sat_pct_r <= '0;
      lit_pct_r <= '0;
      vib_pct_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE: mode_r    <= cfg_wdata[0];
        REG_HUE:  hue_deg_r <= cfg_wdata;
        REG_SAT:  sat_pct_r <= cfg_wdata[7:0];
        REG_LIT:  lit_pct_r <= cfg_wdata[7:0];
        REG_VIB:  vib_pct_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Hue shift in 1536ths of a turn: degrees * 64 / 15, truncated toward
  // zero. It is refreshed every cycle from the stable configuration.
  logic [8:0]         hue_mag;
  logic [24:0]        hue_prod;
  logic signed [11:0] hue_off_nxt, hue_off_r;

  always_comb begin
    hue_mag  = hue_deg_r[8] ? 9'(-hue_deg_r) : hue_deg_r;
    hue_prod = 25'(hue_mag) * 25'd34953;
    hue_off_nxt = hue_deg_r[8] ? -$signed({1'b0, hue_prod[23:13]})
                               : $signed({1'b0, hue_prod[23:13]});
  end

  always_ff @(posedge clk) begin
    hue_off_r <= hue_off_nxt;
  end

  // The whole pipeline moves unless a finished result is being held.
  assign in_stall = out_valid & out_stall;
  assign adv      = ~in_stall;

  // Stage A: input capture.
  logic        a_vld_r;
  logic [31:0] a_pix_r;
  logic [7:0]  a_cov_r;

  // Stage B: min/max, lightness and the two division operands.
  logic [7:0]         b_r0, b_g0, b_b0, b_mx, b_mn, b_d, b_xmag;
  logic [8:0]         b_sum, b_den_s, b_den_h;
  logic [15:0]        b_num_s, b_num_h;
  logic signed [8:0]  b_x;
  hsla_side_t         b_side;

  always_comb begin
    b_r0 = a_pix_r[23:16];
    b_g0 = a_pix_r[15:8];
    b_b0 = a_pix_r[7:0];
    b_mx = (b_r0 > b_g0) ? ((b_r0 > b_b0) ? b_r0 : b_b0) : ((b_g0 > b_b0) ? b_g0 : b_b0);
    b_mn = (b_r0 < b_g0) ? ((b_r0 < b_b0) ? b_r0 : b_b0) : ((b_g0 < b_b0) ? b_g0 : b_b0);
    b_sum = {1'b0, b_mx} + {1'b0, b_mn};
    b_d   = b_mx - b_mn;
    b_side.pixel = a_pix_r;
    b_side.cov   = a_cov_r;
    b_side.lv    = b_sum[8:1];
    b_side.grey  = (b_mx == b_mn);
    b_den_s = (b_sum[8:1] > 8'd127) ? (9'd510 - b_sum) : b_sum;
    if (b_side.grey) begin
      b_den_s = 9'd1;
    end
    b_num_s = {b_d, 8'b0} - {8'b0, b_d};
    priority if (b_mx == b_r0) begin
      b_x = $signed({1'b0, b_g0}) - $signed({1'b0, b_b0});
      b_side.hbase = 11'd0;
    end else if (b_mx == b_g0) begin
      b_x = $signed({1'b0, b_b0}) - $signed({1'b0, b_r0});
      b_side.hbase = 11'd512;
    end else begin
      b_x = $signed({1'b0, b_r0}) - $signed({1'b0, b_g0});
      b_side.hbase = 11'd1024;
    end
    b_side.hneg = b_x[8];
    b_xmag  = b_x[8] ? 8'(-b_x) : b_x[7:0];
    b_num_h = {b_xmag, 8'b0};
    b_den_h = b_side.grey ? 9'd1 : {1'b0, b_d};
  end

  logic       v_vld;
  logic [8:0] v_q_s, v_q_h;
  hsla_side_t v_side;

  hsla_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .vld_in   (a_vld_r),
    .num_s_in (b_num_s),
    .den_s_in (b_den_s),
    .num_h_in (b_num_h),
    .den_h_in (b_den_h),
    .side_in  (b_side),
    .vld_out  (v_vld),
    .q_s_out  (v_q_s),
    .q_h_out  (v_q_h),
    .side_out (v_side)
  );

  // Stage C: final hue, and the products for the saturation, lightness or
  // vibrance scaling.
  logic signed [11:0] c_hv;
  logic signed [12:0] c_hsum;
  logic [10:0]        c_h_nxt;
  logic [7:0]         c_s0_nxt, c_smag, c_lmag, c_vmag, c_s_inv;
  logic [15:0]        c_prod_a_nxt, c_prod_b_nxt;

  always_comb begin
    c_hv = v_side.hneg ? ($signed({1'b0, v_side.hbase}) - $signed({3'b0, v_q_h}))
                       : ($signed({1'b0, v_side.hbase}) + $signed({3'b0, v_q_h}));
    c_hsum = 13'(c_hv) + (mode_r ? 13'sd0 : 13'(hue_off_r));
    priority if (c_hsum < 13'sd0) begin
      c_hsum = c_hsum + 13'sd1536;
    end else if (c_hsum >= 13'sd1536) begin
      c_hsum = c_hsum - 13'sd1536;
    end
    c_h_nxt  = c_hsum[10:0];
    c_s0_nxt = v_side.grey ? 8'd0 : v_q_s[7:0];
    c_smag   = sat_pct_r[7] ? 8'(-sat_pct_r) : sat_pct_r;
    c_lmag   = lit_pct_r[7] ? 8'(-lit_pct_r) : lit_pct_r;
    c_vmag   = vib_pct_r[7] ? 8'(-vib_pct_r) : vib_pct_r;
    c_s_inv  = 8'd255 - c_s0_nxt;
    c_prod_a_nxt = mode_r ? (16'(c_vmag) * 16'(c_s_inv)) : (16'(c_s0_nxt) * 16'(c_smag));
    c_prod_b_nxt = 16'(v_side.lv) * 16'(c_lmag);
  end

  logic        c_vld_r;
  logic [10:0] c_h_r;
  logic [7:0]  c_s0_r, c_l_r;
  logic [15:0] c_prod_a_r, c_prod_b_r;
  logic [31:0] c_pix_r;
  logic [7:0]  c_cov_r;

  // Stage D: divide by 100 (mode 0) or by 255 (vibrance amount).
  logic [8:0]         d_qa, d_qb, d_amt;
  logic signed [11:0] d_sa, d_lb;
  logic [7:0]         d_sa_nxt, d_l_nxt;

  always_comb begin
    d_qa  = div100(c_prod_a_r[14:0]);
    d_qb  = div100(c_prod_b_r[14:0]);
    d_amt = div255({1'b0, c_prod_a_r});
    d_sa  = sat_pct_r[7] ? ($signed({4'b0, c_s0_r}) - $signed({3'b0, d_qa}))
                         : ($signed({4'b0, c_s0_r}) + $signed({3'b0, d_qa}));
    d_lb  = lit_pct_r[7] ? ($signed({4'b0, c_l_r}) - $signed({3'b0, d_qb}))
                         : ($signed({4'b0, c_l_r}) + $signed({3'b0, d_qb}));
    d_sa_nxt = clamp8(d_sa);
    d_l_nxt  = clamp8(d_lb);
  end

  logic        d_vld_r;
  logic [10:0] d_h_r;
  logic [7:0]  d_s0_r, d_sa_r, d_l_r, d_amt_r;
  logic [31:0] d_pix_r;
  logic [7:0]  d_cov_r;

  // Stage E: vibrance product.
  logic [15:0] e_prod_nxt;
  assign e_prod_nxt = 16'(d_s0_r) * 16'(d_amt_r);

  logic        e_vld_r;
  logic [10:0] e_h_r;
  logic [7:0]  e_s0_r, e_sa_r, e_l_r;
  logic [15:0] e_prod_r;
  logic [31:0] e_pix_r;
  logic [7:0]  e_cov_r;

  // Stage F: vibrance saturation, then pick the mode's saturation.
  logic [8:0]         f_q;
  logic signed [11:0] f_sv;
  logic [7:0]         f_s_nxt;

  always_comb begin
    f_q  = div100(e_prod_r[14:0]);
    f_sv = vib_pct_r[7] ? ($signed({4'b0, e_s0_r}) - $signed({3'b0, f_q}))
                        : ($signed({4'b0, e_s0_r}) + $signed({3'b0, f_q}));
    f_s_nxt = mode_r ? clamp8(f_sv) : e_sa_r;
  end

  logic        f_vld_r;
  logic [10:0] f_h_r;
  logic [7:0]  f_s_r, f_l_r;
  logic [31:0] f_pix_r;
  logic [7:0]  f_cov_r;

  // Stage G: product for the upper level of the HSL to RGB conversion.
  logic [8:0]  g_s_ext;
  logic [16:0] g_x_nxt;

  always_comb begin
    g_s_ext = 9'd255 + {1'b0, f_s_r};
    g_x_nxt = f_l_r[7] ? (17'(f_l_r) * 17'(f_s_r)) : (17'(f_l_r) * 17'(g_s_ext));
  end

  logic        g_vld_r;
  logic [10:0] g_h_r;
  logic [7:0]  g_s_r, g_l_r;
  logic [16:0] g_x_r;
  logic [31:0] g_pix_r;
  logic [7:0]  g_cov_r;

  // Stage H: upper and lower levels.
  logic [8:0]         h_q;
  logic signed [10:0] h_hi_nxt, h_lo_nxt;

  always_comb begin
    h_q = div255(g_x_r);
    h_hi_nxt = g_l_r[7] ? ($signed({3'b0, g_l_r}) + $signed({3'b0, g_s_r})
                           - $signed({2'b0, h_q}))
                        : $signed({2'b0, h_q});
    h_lo_nxt = $signed({2'b0, g_l_r, 1'b0}) - h_hi_nxt;
  end

  logic               h_vld_r, h_grey_r;
  logic [10:0]        h_h_r;
  logic [7:0]         h_l_r;
  logic signed [10:0] h_hi_r, h_lo_r;
  logic [31:0]        h_pix_r;
  logic [7:0]         h_cov_r;

  // Stage I: per channel, hue position, class and ramp product.
  logic [10:0]    i_t [3];
  logic [8:0]     i_w [3];
  hsla_chan_cls_t i_cls_nxt [3];
  logic [18:0]    i_prod_nxt [3];
  logic [9:0]     i_span;

  always_comb begin
    i_t[0] = (h_h_r >= 11'd1024) ? (h_h_r - 11'd1024) : (h_h_r + 11'd512);
    i_t[1] = h_h_r;
    i_t[2] = (h_h_r < 11'd512) ? (h_h_r + 11'd1024) : (h_h_r - 11'd512);
    i_span = 10'(h_hi_r - h_lo_r);
    for (int c = 0; c < 3; c++) begin
      i_w[c] = 9'd0;
      priority if (i_t[c] < 11'd256) begin
        i_cls_nxt[c] = CH_RAMP;
        i_w[c] = i_t[c][8:0];
      end else if (i_t[c] < 11'd768) begin
        i_cls_nxt[c] = CH_HI;
      end else if (i_t[c] < 11'd1024) begin
        i_cls_nxt[c] = CH_RAMP;
        i_w[c] = 9'(11'd1024 - i_t[c]);
      end else begin
        i_cls_nxt[c] = CH_LO;
      end
      i_prod_nxt[c] = 19'(i_span) * 19'(i_w[c]);
    end
  end

  logic               i_vld_r, i_grey_r;
  hsla_chan_cls_t     i_cls_r [3];
  logic [18:0]        i_prod_r [3];
  logic [7:0]         i_l_r;
  logic signed [10:0] i_hi_r, i_lo_r;
  logic [31:0]        i_pix_r;
  logic [7:0]         i_cov_r;

  // Stage J: channel value, difference to the original and blend product.
  logic [7:0]         j_orig [3];
  logic signed [11:0] j_val [3];
  logic [7:0]         j_ch [3];
  logic signed [9:0]  j_diff [3];
  logic [7:0]         j_mag [3];
  logic [15:0]        j_prod_nxt [3];
  logic               j_neg_nxt [3];

  always_comb begin
    j_orig[0] = i_pix_r[23:16];
    j_orig[1] = i_pix_r[15:8];
    j_orig[2] = i_pix_r[7:0];
    for (int c = 0; c < 3; c++) begin
      unique case (i_cls_r[c])
        CH_RAMP: j_val[c] = 12'(i_lo_r) + $signed({1'b0, i_prod_r[c][18:8]});
        CH_HI:   j_val[c] = 12'(i_hi_r);
        CH_LO:   j_val[c] = 12'(i_lo_r);
        default: j_val[c] = 12'(i_lo_r);
      endcase
      j_ch[c]   = i_grey_r ? i_l_r : clamp8(j_val[c]);
      j_diff[c] = $signed({2'b0, j_ch[c]}) - $signed({2'b0, j_orig[c]});
      j_neg_nxt[c]  = j_diff[c][9];
      j_mag[c]      = j_diff[c][9] ? 8'(-j_diff[c]) : j_diff[c][7:0];
      j_prod_nxt[c] = 16'(j_mag[c]) * 16'(i_cov_r);
    end
  end

  logic        j_vld_r;
  logic [15:0] j_prod_r [3];
  logic        j_neg_r [3];
  logic [31:0] j_pix_r;

  // Stage K: blend result into the output register.
  logic [7:0] k_orig [3];
  logic [8:0] k_q [3];
  logic [7:0] k_res [3];

  always_comb begin
    k_orig[0] = j_pix_r[23:16];
    k_orig[1] = j_pix_r[15:8];
    k_orig[2] = j_pix_r[7:0];
    for (int c = 0; c < 3; c++) begin
      k_q[c]   = div255({1'b0, j_prod_r[c]});
      k_res[c] = j_neg_r[c] ? (k_orig[c] - k_q[c][7:0]) : (k_orig[c] + k_q[c][7:0]);
    end
  end

  logic        out_vld_r;
  logic [31:0] out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      f_vld_r   <= 1'b0;
      g_vld_r   <= 1'b0;
      h_vld_r   <= 1'b0;
      i_vld_r   <= 1'b0;
      j_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r   <= in_valid;
      c_vld_r   <= v_vld;
      d_vld_r   <= c_vld_r;
      e_vld_r   <= d_vld_r;
      f_vld_r   <= e_vld_r;
      g_vld_r   <= f_vld_r;
      h_vld_r   <= g_vld_r;
      i_vld_r   <= h_vld_r;
      j_vld_r   <= i_vld_r;
      out_vld_r <= j_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pix_r    <= in_pixel_in;
      a_cov_r    <= in_coverage;

      c_h_r      <= c_h_nxt;
      c_s0_r     <= c_s0_nxt;
      c_l_r      <= v_side.lv;
      c_prod_a_r <= c_prod_a_nxt;
      c_prod_b_r <= c_prod_b_nxt;
      c_pix_r    <= v_side.pixel;
      c_cov_r    <= v_side.cov;

      d_h_r      <= c_h_r;
      d_s0_r     <= c_s0_r;
      d_sa_r     <= d_sa_nxt;
      d_l_r      <= mode_r ? c_l_r : d_l_nxt;
      d_amt_r    <= d_amt[7:0];
      d_pix_r    <= c_pix_r;
      d_cov_r    <= c_cov_r;

      e_h_r      <= d_h_r;
      e_s0_r     <= d_s0_r;
      e_sa_r     <= d_sa_r;
      e_l_r      <= d_l_r;
      e_prod_r   <= e_prod_nxt;
      e_pix_r    <= d_pix_r;
      e_cov_r    <= d_cov_r;

      f_h_r      <= e_h_r;
      f_s_r      <= f_s_nxt;
      f_l_r      <= e_l_r;
      f_pix_r    <= e_pix_r;
      f_cov_r    <= e_cov_r;

      g_h_r      <= f_h_r;
      g_s_r      <= f_s_r;
      g_l_r      <= f_l_r;
      g_x_r      <= g_x_nxt;
      g_pix_r    <= f_pix_r;
      g_cov_r    <= f_cov_r;

      h_h_r      <= g_h_r;
      h_l_r      <= g_l_r;
      h_grey_r   <= (g_s_r == 8'd0);
      h_hi_r     <= h_hi_nxt;
      h_lo_r     <= h_lo_nxt;
      h_pix_r    <= g_pix_r;
      h_cov_r    <= g_cov_r;

      i_grey_r   <= h_grey_r;
      i_l_r      <= h_l_r;
      i_hi_r     <= h_hi_r;
      i_lo_r     <= h_lo_r;
      i_pix_r    <= h_pix_r;
      i_cov_r    <= h_cov_r;

      j_pix_r    <= i_pix_r;

      out_pix_r  <= {j_pix_r[31:24], k_res[0], k_res[1], k_res[2]};

      for (int c = 0; c < 3; c++) begin
        i_cls_r[c]  <= i_cls_nxt[c];
        i_prod_r[c] <= i_prod_nxt[c];
        j_prod_r[c] <= j_prod_nxt[c];
        j_neg_r[c]  <= j_neg_nxt[c];
      end
    end
  end

  assign out_valid     = out_vld_r;
  assign out_pixel_out = out_pix_r;

endmodule

/* src/hsla_div_pipe.sv */
// ----------------------------------------------------------------------------
// hsla_div_pipe: two pipelined restoring dividers sharing one sideband.
// Each stage resolves one quotient bit, most significant first.
// ----------------------------------------------------------------------------
module hsla_div_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  logic [15:0]         num_s_in,
  input  logic [8:0]          den_s_in,
  input  logic [15:0]         num_h_in,
  input  logic [8:0]          den_h_in,
  input  hsla_pkg::hsla_side_t side_in,
  output logic                vld_out,
  output logic [8:0]          q_s_out,
  output logic [8:0]          q_h_out,
  output hsla_pkg::hsla_side_t side_out
);
  import hsla_pkg::*;

  logic             vld_r   [DIV_STEPS];
  logic [15:0]      rem_s_r [DIV_STEPS];
  logic [15:0]      rem_h_r [DIV_STEPS];
  logic [8:0]       den_s_r [DIV_STEPS];
  logic [8:0]       den_h_r [DIV_STEPS];
  logic [8:0]       q_s_r   [DIV_STEPS];
  logic [8:0]       q_h_r   [DIV_STEPS];
  hsla_side_t       side_r  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    logic        vld_p;
    logic [15:0] rem_s_p, rem_h_p;
    logic [8:0]  den_s_p, den_h_p, q_s_p, q_h_p;
    hsla_side_t  side_p;
    logic [17:0] sub_s, sub_h;
    logic        ge_s, ge_h;

    if (k == 0) begin : g_first
      assign vld_p   = vld_in;
      assign rem_s_p = num_s_in;
      assign rem_h_p = num_h_in;
      assign den_s_p = den_s_in;
      assign den_h_p = den_h_in;
      assign q_s_p   = 9'd0;
      assign q_h_p   = 9'd0;
      assign side_p  = side_in;
    end else begin : g_next
      assign vld_p   = vld_r[k-1];
      assign rem_s_p = rem_s_r[k-1];
      assign rem_h_p = rem_h_r[k-1];
      assign den_s_p = den_s_r[k-1];
      assign den_h_p = den_h_r[k-1];
      assign q_s_p   = q_s_r[k-1];
      assign q_h_p   = q_h_r[k-1];
      assign side_p  = side_r[k-1];
    end

    assign sub_s = 18'(den_s_p) << (DIV_STEPS - 1 - k);
    assign sub_h = 18'(den_h_p) << (DIV_STEPS - 1 - k);
    assign ge_s  = 18'(rem_s_p) >= sub_s;
    assign ge_h  = 18'(rem_h_p) >= sub_h;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s_r[k] <= ge_s ? (rem_s_p - sub_s[15:0]) : rem_s_p;
        rem_h_r[k] <= ge_h ? (rem_h_p - sub_h[15:0]) : rem_h_p;
        den_s_r[k] <= den_s_p;
        den_h_r[k] <= den_h_p;
        q_s_r[k]   <= {q_s_p[7:0], ge_s};
        q_h_r[k]   <= {q_h_p[7:0], ge_h};
        side_r[k]  <= side_p;
      end
    end
  end

  assign vld_out  = vld_r[DIV_STEPS-1];
  assign q_s_out  = q_s_r[DIV_STEPS-1];
  assign q_h_out  = q_h_r[DIV_STEPS-1];
  assign side_out = side_r[DIV_STEPS-1];

endmodule
